FILE: src/p2ba_pkg.sv
// ----------------------------------------------------------------------------
// p2ba_pkg
// Shared constants, register indexes and types for the 2x2 block-average
// pixelation block.
// ----------------------------------------------------------------------------
package p2ba_pkg;

    localparam int MAX_BLOCK_COLUMNS = 256;
    localparam int MAX_BLOCK_ROWS    = 256;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 9;
    localparam int SIZE_W  = 9;
    localparam int SUM_W   = 9;
    localparam int LINE_AW = $clog2(MAX_BLOCK_COLUMNS);

    localparam logic [0:0] REG_BLOCK_COLUMNS = 1'b0;
    localparam logic [0:0] REG_BLOCK_ROWS    = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [SUM_W-1:0]   pair_sum;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last_of_frame;
    } blk_req_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] res;
        if (v == '0)
            res = SIZE_W'(1);
        else if (v > maxv)
            res = maxv;
        else
            res = v;
        return res;
    endfunction

endpackage

FILE: src/p2ba_line_ram.sv
// ----------------------------------------------------------------------------
// p2ba_line_ram
// Simple dual-port line store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module p2ba_line_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/p2ba_raster_ctrl.sv
// ----------------------------------------------------------------------------
// p2ba_raster_ctrl
// Raster counters, held pixel and line store access. Even rows write pair
// sums; odd rows read them back and pass a block request downstream.
// ----------------------------------------------------------------------------
module p2ba_raster_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [p2ba_pkg::SIZE_W-1:0]           block_columns,
    input  logic [p2ba_pkg::SIZE_W-1:0]           block_rows,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [p2ba_pkg::PIX_W-1:0]            pixel,
    input  logic                                  pend_busy,
    output logic                                  ram_we,
    output logic [p2ba_pkg::LINE_AW-1:0]          ram_waddr,
    output logic [p2ba_pkg::SUM_W-1:0]            ram_wdata,
    output logic                                  ram_re,
    output logic [p2ba_pkg::LINE_AW-1:0]          ram_raddr,
    output p2ba_pkg::blk_req_t                    req
);
    import p2ba_pkg::*;

    logic [PIX_W-1:0]   held_reg, held_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_reg, col_next;
    blk_req_t           req_reg, req_next;

    logic [SIZE_W-1:0]  wb, hb;
    logic [SIZE_W:0]    wpix, hpix;
    logic               col_end, row_end;
    logic               produce, fire;
    logic [SUM_W-1:0]   pair_sum;

    assign wb   = clamp_size(block_columns, SIZE_W'(MAX_BLOCK_COLUMNS));
    assign hb   = clamp_size(block_rows, SIZE_W'(MAX_BLOCK_ROWS));
    assign wpix = {wb, 1'b0};
    assign hpix = {hb, 1'b0};

    assign col_end  = ({1'b0, col_reg} + (SIZE_W+1)'(1)) >= wpix;
    assign row_end  = ({1'b0, row_reg} + (SIZE_W+1)'(1)) >= hpix;
    assign produce  = col_reg[0] & row_reg[0];
    assign in_ready = !produce || (!req_reg.valid && !pend_busy);
    assign fire     = in_valid && in_ready;
    assign pair_sum = {1'b0, held_reg} + {1'b0, pixel};

    always_comb
    begin
        held_next = held_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        req_next  = req_reg;

        req_next.valid         = fire && produce;
        req_next.pair_sum      = pair_sum;
        req_next.row           = row_reg;
        req_next.col           = col_reg;
        req_next.last_of_frame = row_end && col_end;

        if (fire)
        begin
            if (!col_reg[0])
            begin
                held_next = pixel;
            end
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + COORD_W'(1);
            end
            else
            begin
                col_next = col_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            req_reg  <= '0;
        end
        else
        begin
            held_reg <= held_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            req_reg  <= req_next;
        end
    end

    assign ram_we    = fire && col_reg[0] && !row_reg[0];
    assign ram_waddr = col_reg[LINE_AW:1];
    assign ram_wdata = pair_sum;
    assign ram_re    = fire && produce;
    assign ram_raddr = col_reg[LINE_AW:1];
    assign req       = req_reg;

endmodule

FILE: src/p2ba_block_emit.sv
// ----------------------------------------------------------------------------
// p2ba_block_emit
// Completes the block average from the line store data and sends it four
// times, once per pixel position of the block.
// ----------------------------------------------------------------------------
module p2ba_block_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  p2ba_pkg::blk_req_t            req,
    input  logic [p2ba_pkg::SUM_W-1:0]    ram_rdata,
    output logic                          pend_busy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [p2ba_pkg::PIX_W-1:0]    value,
    output logic [p2ba_pkg::COORD_W-1:0]  out_row,
    output logic [p2ba_pkg::COORD_W-1:0]  out_col,
    output logic                          last_of_block,
    output logic                          last_of_frame
);
    import p2ba_pkg::*;

    logic               pend_valid_reg, pend_valid_next;
    logic [PIX_W-1:0]   pend_avg_reg, pend_avg_next;
    logic [COORD_W-1:0] pend_row_reg, pend_row_next;
    logic [COORD_W-1:0] pend_col_reg, pend_col_next;
    logic               pend_lf_reg, pend_lf_next;

    logic               act_valid_reg, act_valid_next;
    logic [PIX_W-1:0]   act_avg_reg, act_avg_next;
    logic [COORD_W-1:0] act_row_reg, act_row_next;
    logic [COORD_W-1:0] act_col_reg, act_col_next;
    logic               act_lf_reg, act_lf_next;
    logic [1:0]         beat_reg, beat_next;

    logic [SUM_W:0]     sum4;
    logic               out_fire, act_done, act_free;

    assign sum4     = {1'b0, ram_rdata} + {1'b0, req.pair_sum};
    assign out_fire = act_valid_reg && out_ready;
    assign act_done = out_fire && (beat_reg == 2'd3);
    assign act_free = !act_valid_reg || act_done;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_avg_next   = pend_avg_reg;
        pend_row_next   = pend_row_reg;
        pend_col_next   = pend_col_reg;
        pend_lf_next    = pend_lf_reg;
        act_valid_next  = act_valid_reg;
        act_avg_next    = act_avg_reg;
        act_row_next    = act_row_reg;
        act_col_next    = act_col_reg;
        act_lf_next     = act_lf_reg;
        beat_next       = beat_reg;

        if (out_fire)
        begin
            beat_next = beat_reg + 2'd1;
        end
        if (act_done)
        begin
            act_valid_next = 1'b0;
        end

        if (act_free && pend_valid_reg)
        begin
            act_valid_next  = 1'b1;
            act_avg_next    = pend_avg_reg;
            act_row_next    = pend_row_reg;
            act_col_next    = pend_col_reg;
            act_lf_next     = pend_lf_reg;
            beat_next       = 2'd0;
            pend_valid_next = 1'b0;
        end

        if (req.valid)
        begin
            pend_valid_next = 1'b1;
            pend_avg_next   = sum4[SUM_W:2];
            pend_row_next   = req.row;
            pend_col_next   = req.col;
            pend_lf_next    = req.last_of_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            act_valid_reg  <= 1'b0;
            beat_reg       <= 2'd0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            act_valid_reg  <= act_valid_next;
            beat_reg       <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_avg_reg <= pend_avg_next;
        pend_row_reg <= pend_row_next;
        pend_col_reg <= pend_col_next;
        pend_lf_reg  <= pend_lf_next;
        act_avg_reg  <= act_avg_next;
        act_row_reg  <= act_row_next;
        act_col_reg  <= act_col_next;
        act_lf_reg   <= act_lf_next;
    end

    assign pend_busy     = pend_valid_reg;
    assign out_valid     = act_valid_reg;
    assign value         = act_avg_reg;
    assign out_row       = beat_reg[1] ? act_row_reg : act_row_reg - COORD_W'(1);
    assign out_col       = beat_reg[0] ? act_col_reg : act_col_reg - COORD_W'(1);
    assign last_of_block = (beat_reg == 2'd3);
    assign last_of_frame = (beat_reg == 2'd3) && act_lf_reg;

endmodule

FILE: src/pixelate_2x2_block_average_top.sv
// ----------------------------------------------------------------------------
// pixelate_2x2_block_average_top
// 2x2 block-average pixelation of a grey raster stream.
// ----------------------------------------------------------------------------
// Grey pixels enter in raster order, one per transfer. On even rows a pixel
// is taken every cycle and horizontal pair sums go to a 256-entry line store.
// On odd rows the second pixel of each pair reads the line store and
// produces four output transfers, one per cycle while m_tready is high,
// from a single output port, so input on odd rows is paced by the output;
// a block buffer lets the next block be read while the current one is sent.
// The line store needs no clearing after reset. Frame sizes are given in
// blocks; a size of zero acts as one.
module pixelate_2x2_block_average_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] value, [16:8] out_row, [25:17] out_col
    output logic        m_tlast,   // last_of_block
    output logic        m_tuser    // last_of_frame
);
    import p2ba_pkg::*;

    logic [SIZE_W-1:0]  block_columns_reg;
    logic [SIZE_W-1:0]  block_rows_reg;

    logic               ram_we, ram_re;
    logic [LINE_AW-1:0] ram_waddr, ram_raddr;
    logic [SUM_W-1:0]   ram_wdata, ram_rdata;
    logic               pend_busy;
    blk_req_t           req;

    logic [PIX_W-1:0]   value;
    logic [COORD_W-1:0] out_row, out_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_columns_reg <= SIZE_W'(256);
            block_rows_reg    <= SIZE_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_COLUMNS: block_columns_reg <= cfg_data;
                REG_BLOCK_ROWS:    block_rows_reg    <= cfg_data;
                default:           block_rows_reg    <= block_rows_reg;
            endcase
        end
    end

    p2ba_raster_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .block_columns (block_columns_reg),
        .block_rows    (block_rows_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .pixel         (s_tdata),
        .pend_busy     (pend_busy),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .req           (req)
    );

    p2ba_line_ram #(
        .DEPTH (MAX_BLOCK_COLUMNS),
        .WIDTH (SUM_W)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    p2ba_block_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .ram_rdata     (ram_rdata),
        .pend_busy     (pend_busy),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .value         (value),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_block (m_tlast),
        .last_of_frame (m_tuser)
    );

    assign m_tdata = {6'b0, out_col, out_row, value};

    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("line store read and write in the same cycle");

    a_req_into_free_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> !pend_busy)
        else $error("block request arrived while the block buffer was full");

    a_frame_end_is_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("end of frame flagged on a transfer that does not end a block");

    a_block_end_odd_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (out_row[0] && out_col[0]))
        else $error("block end at an even row or column");

endmodule
